[sv/ghtk_pkg.sv]
// Shared types and constants for the grid histogram top-k cell selector.
// No dependencies; used by ghtk_best and the top level.
package ghtk_pkg;

	localparam int XY_W    = 7;
	localparam int TOTAL_W = 24;
	localparam int PICK_W  = 7;
	localparam logic [31:0] TOTAL_MAX = 32'h00FF_FFFF;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_LOAD  = 6'b000100,
		ST_SCAN  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_PICK  = 6'b100000
	} state_t;

	typedef struct packed {
		logic empty;
		logic single;
	} scan_stat_t;

endpackage

[sv/ghtk_mem.sv]
// Visit counter store: one write port, one registered read port.
// Depends on nothing but its parameters.
module ghtk_mem #(
	parameter int DEPTH  = 16384,
	parameter int ADDR_W = 14,
	parameter int DATA_W = 24
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[sv/ghtk_best.sv]
// Running maximum unit: keeps the first cell with the highest count over one scan.
// Uses ghtk_pkg for the scan status struct.
module ghtk_best import ghtk_pkg::*; #(
	parameter int X_W        = 7,
	parameter int Y_W        = 7,
	parameter int ADDR_W     = 14,
	parameter int COUNT_BITS = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr,
	input  logic                  vld,
	input  logic [COUNT_BITS-1:0] cnt,
	input  logic [X_W-1:0]        x,
	input  logic [Y_W-1:0]        y,
	input  logic [ADDR_W-1:0]     addr,
	output logic [COUNT_BITS-1:0] best_cnt,
	output logic [X_W-1:0]        best_x,
	output logic [Y_W-1:0]        best_y,
	output logic [ADDR_W-1:0]     best_addr,
	output scan_stat_t            stat
);

	logic [COUNT_BITS-1:0] cnt_q;
	logic [X_W-1:0]        x_q;
	logic [Y_W-1:0]        y_q;
	logic [ADDR_W-1:0]     addr_q;
	logic [1:0]            nz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			nz_q  <= '0;
		end else if (clr) begin
			cnt_q <= '0;
			nz_q  <= '0;
		end else if (vld) begin
			if (cnt > cnt_q) begin
				cnt_q <= cnt;
			end
			if (cnt != '0 && nz_q != 2'd2) begin
				nz_q <= nz_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld && !clr && cnt > cnt_q) begin
			x_q    <= x;
			y_q    <= y;
			addr_q <= addr;
		end
	end

	assign best_cnt    = cnt_q;
	assign best_x      = x_q;
	assign best_y      = y_q;
	assign best_addr   = addr_q;
	assign stat.empty  = (nz_q == 2'd0);
	assign stat.single = (nz_q == 2'd1);

endmodule

[sv/grid_histogram_top_k_cells.sv]
// Top level: record loading, selection sequencer and output word register.
// Depends on ghtk_pkg, ghtk_mem and ghtk_best.
//
//   channel   direction  payload                                 handshake
//   s_axis    in         tdata: cell_x, cell_y; tlast: last_rec  tvalid/tready
//   m_axis    out        tdata: pick_x, pick_y, visit_total;     tvalid/tready
//                        tlast: final_pick
//   cfg       in         data: pick_count                        valid/ready
//
// A record takes one counter read and one write on the store's ports.
// A record marked last then costs one full scan through the single read port per
// selected cell, plus a pass over every cell to clear the store.
// After reset the store is cleared, tready held low.
// A stalled output word holds; the next pick waits only if the register is full.
module grid_histogram_top_k_cells import ghtk_pkg::*; #(
	parameter int GRID_W     = 128,
	parameter int GRID_H     = 128,
	parameter int MAX_PICKS  = 64,
	parameter int COUNT_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // cell_x[6:0], cell_y[13:7], zero[15:14]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // pick_x[6:0], pick_y[13:7], visit_total[37:14], zero
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);

	localparam int CELLS  = GRID_W * GRID_H;
	localparam int ADDR_W = $clog2(CELLS);
	localparam int X_W    = $clog2(GRID_W);
	localparam int Y_W    = $clog2(GRID_H);
	localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [X_W-1:0]        LAST_X    = X_W'(GRID_W - 1);
	localparam logic [Y_W-1:0]        LAST_Y    = Y_W'(GRID_H - 1);
	localparam logic [PICK_W-1:0]     MAXP      = PICK_W'(MAX_PICKS);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	state_t state_q, state_d;

	logic [PICK_W-1:0] pick_count_q, limit_q, pick_num_q, cap;
	logic [ADDR_W-1:0] addr_q, ld_addr_q;
	logic [X_W-1:0]    scan_x_q, scan_x_s1;
	logic [Y_W-1:0]    scan_y_q, scan_y_s1;
	logic [ADDR_W-1:0] scan_addr_s1;
	logic              scan_vld_s1;
	logic              ld_ok_q, ld_last_q;

	logic [XY_W-1:0]   in_x, in_y;
	logic              in_ok, in_acc;
	logic [ADDR_W-1:0] in_idx;

	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
	logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

	logic                  best_clr;
	logic [COUNT_BITS-1:0] best_cnt;
	logic [X_W-1:0]        best_x;
	logic [Y_W-1:0]        best_y;
	logic [ADDR_W-1:0]     best_addr;
	scan_stat_t            stat;

	logic              ld_out, final_d, start_sel, enter_clr;
	logic [31:0]       cnt32;
	logic [TOTAL_W-1:0] total_d;
	logic [XY_W-1:0]   out_x_q, out_y_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic              out_last_q, out_valid_q;

	assign in_x   = s_axis_tdata[6:0];
	assign in_y   = s_axis_tdata[13:7];
	assign in_ok  = (32'(in_x) < GRID_W) && (32'(in_y) < GRID_H);
	assign in_idx = ADDR_W'(32'(in_x) * 32'(GRID_H) + 32'(in_y));
	assign in_acc = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign cap           = (pick_count_q > MAXP) ? MAXP : pick_count_q;

	assign cnt32   = 32'(best_cnt);
	assign total_d = (cnt32 > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(cnt32);
	assign final_d = (pick_num_q + PICK_W'(1) == limit_q) || stat.single;
	assign ld_out  = (state_q == ST_PICK) && !stat.empty && (!out_valid_q || m_axis_tready);

	always_comb begin
		state_d   = state_q;
		start_sel = 1'b0;
		enter_clr = 1'b0;
		best_clr  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (!ld_last_q) begin
					state_d = ST_IDLE;
				end else if (cap == '0) begin
					state_d   = ST_CLEAR;
					enter_clr = 1'b1;
				end else begin
					state_d   = ST_SCAN;
					start_sel = 1'b1;
					best_clr  = 1'b1;
				end
			end
			ST_SCAN: begin
				if (scan_x_q == LAST_X && scan_y_q == LAST_Y) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (stat.empty) begin
					state_d   = ST_CLEAR;
					enter_clr = 1'b1;
				end else if (ld_out) begin
					if (final_d) begin
						state_d   = ST_CLEAR;
						enter_clr = 1'b1;
					end else begin
						state_d  = ST_SCAN;
						best_clr = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			pick_count_q <= PICK_W'(1);
			limit_q      <= '0;
			pick_num_q   <= '0;
			addr_q       <= '0;
			scan_x_q     <= '0;
			scan_y_q     <= '0;
			scan_vld_s1  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			scan_vld_s1 <= (state_q == ST_SCAN);
			if (cfg_valid && cfg_ready) begin
				pick_count_q <= cfg_data;
			end
			if (start_sel) begin
				limit_q    <= cap;
				pick_num_q <= '0;
			end else if (ld_out) begin
				pick_num_q <= pick_num_q + PICK_W'(1);
			end
			if (enter_clr) begin
				addr_q <= '0;
			end else if (state_q == ST_CLEAR) begin
				addr_q <= addr_q + ADDR_W'(1);
			end
			if (best_clr) begin
				scan_x_q <= '0;
				scan_y_q <= '0;
				addr_q   <= '0;
			end else if (state_q == ST_SCAN) begin
				addr_q <= addr_q + ADDR_W'(1);
				if (scan_y_q == LAST_Y) begin
					scan_y_q <= '0;
					scan_x_q <= scan_x_q + X_W'(1);
				end else begin
					scan_y_q <= scan_y_q + Y_W'(1);
				end
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_x_s1    <= scan_x_q;
		scan_y_s1    <= scan_y_q;
		scan_addr_s1 <= addr_q;
		if (in_acc) begin
			ld_addr_q <= in_idx;
			ld_ok_q   <= in_ok;
			ld_last_q <= s_axis_tlast;
		end
		if (ld_out) begin
			out_x_q     <= XY_W'(32'(best_x));
			out_y_q     <= XY_W'(32'(best_y));
			out_total_q <= total_d;
			out_last_q  <= final_d;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_LOAD: begin
				mem_we    = ld_ok_q;
				mem_waddr = ld_addr_q;
				mem_wdata = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + COUNT_BITS'(1);
			end
			ST_PICK: begin
				mem_we    = ld_out;
				mem_waddr = best_addr;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign mem_raddr = (state_q == ST_IDLE) ? in_idx : addr_q;

	ghtk_mem #(
		.DEPTH (CELLS),
		.ADDR_W(ADDR_W),
		.DATA_W(COUNT_BITS)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	ghtk_best #(
		.X_W       (X_W),
		.Y_W       (Y_W),
		.ADDR_W    (ADDR_W),
		.COUNT_BITS(COUNT_BITS)
	) u_best (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (best_clr),
		.vld      (scan_vld_s1),
		.cnt      (mem_rdata),
		.x        (scan_x_s1),
		.y        (scan_y_s1),
		.addr     (scan_addr_s1),
		.best_cnt (best_cnt),
		.best_x   (best_x),
		.best_y   (best_y),
		.best_addr(best_addr),
		.stat     (stat)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_total_q, out_y_q, out_x_q};
	assign m_axis_tlast  = out_last_q;

endmodule

[sv/ghtk_checker.sv]
// Port-level checks for the grid histogram top-k cell selector, bound to the top.
// Depends on the top level's ports only.
module ghtk_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata,
	input logic        m_axis_tlast,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken on the cycle after a word was accepted");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
			&& $stable(m_axis_tlast))
		else $error("stalled output word changed");

	a_total_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[37:14] != 24'd0)
		else $error("output word with a zero visit total");

	a_sel_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
		else $error("input taken before selection finished");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration word refused");

endmodule

bind grid_histogram_top_k_cells ghtk_checker u_ghtk_checker (.*);
